/* sv/cfel_pkg.sv */
// Shared types, widths and register codes of the calibration flag edge latch.
package cfel_pkg;

    localparam int TURN_BITS_DEF = 16;
    localparam int POS_W         = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int IN_TDATA_W    = 96;
    localparam int OUT_FIELDS_W  = 67;
    localparam int OUT_TDATA_W   = 72;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONTINUOUS = 3'd0,
        CFG_RISE_EN    = 3'd1,
        CFG_FALL_EN    = 3'd2,
        CFG_RISE_ANGLE = 3'd3,
        CFG_FALL_ANGLE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic                    continuous;
        logic                    rise_en;
        logic                    fall_en;
        logic signed [POS_W-1:0] rise_angle;
        logic signed [POS_W-1:0] fall_angle;
    } t_cfg;

    typedef struct packed {
        logic                    primed;
        logic                    level;
        logic signed [POS_W-1:0] offset;
        logic signed [POS_W-1:0] actuator;
        logic                    rise_flag;
        logic signed [POS_W-1:0] rise_latch;
        logic                    fall_flag;
        logic signed [POS_W-1:0] fall_latch;
    } t_state;

endpackage

/* sv/calibration_flag_edge_latch_unit.sv */
// Top level of the calibration flag edge latch: handshakes, registers and state.
//
//  channel   direction  handshake                 payload
//  s (in)    input      i_s_tvalid / o_s_tready   i_s_tdata, 96 bits
//  m (out)   output     o_m_tvalid / i_m_tready   o_m_tdata, 72 bits
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One item is taken per clock while the output keeps taking results. An accepted
// item is held in the input register, then the flag and edge logic updates the joint
// state and loads the result register, from which the result is offered on o_m_tvalid
// and is taken at the first edge on which the output is free.
// The input register moves on whenever the result register is empty or being taken,
// so a full rate stream flows with no bubbles; a stall on the output backs up into
// o_s_tready after both registers are full. Reset (synchronous, active low) clears
// the configuration, the joint state and both valid flags. Configuration is always
// accepted; writes to indexes beyond the register list are ignored.
module calibration_flag_edge_latch_unit
    import cfel_pkg::*;
#(
    parameter int TURN_BITS = TURN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // joint_position [31:0], reference_position [63:32], actuator_position [95:64]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // flag_level [0], rise_seen [1], rise_position [33:2], fall_seen [34],
    // fall_position [66:35], zeros [71:67]
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [POS_W-1:0]       i_cfg_data
);

    t_cfg                    r_cfg;
    t_state                  r_state;
    t_state                  n_state;
    logic                    r_in_valid;
    logic signed [POS_W-1:0] r_in_joint;
    logic signed [POS_W-1:0] r_in_reference;
    logic signed [POS_W-1:0] r_in_actuator;
    logic                    r_out_valid;
    logic [OUT_TDATA_W-1:0]  r_out_data;
    logic                    out_free;
    logic                    advance;
    logic                    in_accept;

    assign out_free    = !r_out_valid || i_m_tready;
    assign advance     = r_in_valid && out_free;
    assign o_s_tready  = !r_in_valid || out_free;
    assign in_accept   = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;

    // Configuration registers; the angles are kept at full width, the wrap in
    // continuous mode only looks at the fraction of a turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CONTINUOUS: r_cfg.continuous <= i_cfg_data[0];
                CFG_RISE_EN:    r_cfg.rise_en    <= i_cfg_data[0];
                CFG_FALL_EN:    r_cfg.fall_en    <= i_cfg_data[0];
                CFG_RISE_ANGLE: r_cfg.rise_angle <= i_cfg_data;
                CFG_FALL_ANGLE: r_cfg.fall_angle <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_joint     <= i_s_tdata[POS_W-1:0];
            r_in_reference <= i_s_tdata[2*POS_W-1:POS_W];
            r_in_actuator  <= i_s_tdata[3*POS_W-1:2*POS_W];
        end
    end

    cfel_core #(
        .TURN_BITS (TURN_BITS)
    ) u_core (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_joint     (r_in_joint),
        .i_reference (r_in_reference),
        .i_actuator  (r_in_actuator),
        .o_state     (n_state)
    );

    // The joint state moves on together with each item entering the result register,
    // so the next item always sees the state left by the one before it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                           n_state.fall_latch, n_state.fall_flag,
                           n_state.rise_latch, n_state.rise_flag,
                           n_state.level};
        end
    end

endmodule

/* sv/cfel_core.sv */
// Flag level decision and edge capture for one sample, purely combinational.
module cfel_core
    import cfel_pkg::*;
#(
    parameter int TURN_BITS = TURN_BITS_DEF
) (
    input  t_cfg                    i_cfg,
    input  t_state                  i_state,
    input  logic signed [POS_W-1:0] i_joint,
    input  logic signed [POS_W-1:0] i_reference,
    input  logic signed [POS_W-1:0] i_actuator,
    output t_state                  o_state
);

    localparam logic [TURN_BITS-1:0] HALF_TURN = {1'b1, {(TURN_BITS-1){1'b0}}};

    // Wrap into (-half, +half]: values above half a turn become negative.
    function automatic logic signed [TURN_BITS:0] wrap_turn(input logic [TURN_BITS-1:0] v);
        wrap_turn = (v > HALF_TURN) ? {1'b1, v} : {1'b0, v};
    endfunction

    logic signed [POS_W:0]     diff;
    logic signed [POS_W-1:0]   pos;
    logic [TURN_BITS-1:0]      rise_u;
    logic [TURN_BITS-1:0]      fall_u;
    logic signed [TURN_BITS:0] rc;
    logic signed [TURN_BITS:0] fc;
    logic signed [TURN_BITS:0] pc;
    logic                      level;
    logic                      up;
    logic                      rising_edge;

    assign diff = {i_joint[POS_W-1], i_joint} - {i_reference[POS_W-1], i_reference};

    // Saturate the offset to the signed 32-bit range.
    always_comb begin
        if (diff[POS_W] != diff[POS_W-1]) begin
            pos = diff[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            pos = diff[POS_W-1:0];
        end
    end

    always_comb begin
        rise_u = i_cfg.rise_angle[TURN_BITS-1:0];
        fall_u = i_cfg.fall_angle[TURN_BITS-1:0];
        if (i_cfg.rise_en && !i_cfg.fall_en) begin
            fall_u = i_cfg.rise_angle[TURN_BITS-1:0] + HALF_TURN;
        end
        if (!i_cfg.rise_en && i_cfg.fall_en) begin
            rise_u = i_cfg.fall_angle[TURN_BITS-1:0] + HALF_TURN;
        end
    end

    assign rc = wrap_turn(rise_u);
    assign fc = wrap_turn(fall_u);
    assign pc = wrap_turn(diff[TURN_BITS-1:0]);

    always_comb begin
        if (i_cfg.continuous) begin
            if (rc < fc) begin
                level = (pc > rc) && (pc < fc);
            end else begin
                level = !((pc < rc) && (pc > fc));
            end
        end else if (i_cfg.rise_en) begin
            level = pos > i_cfg.rise_angle;
        end else if (i_cfg.fall_en) begin
            level = pos < i_cfg.fall_angle;
        end else begin
            level = i_state.level;
        end
    end

    assign up          = pos > i_state.offset;
    assign rising_edge = level ? up : !up;

    always_comb begin
        o_state = i_state;
        if (i_state.primed && (level != i_state.level)) begin
            if (rising_edge) begin
                o_state.rise_flag  = 1'b1;
                o_state.rise_latch = i_state.actuator;
            end else begin
                o_state.fall_flag  = 1'b1;
                o_state.fall_latch = i_state.actuator;
            end
        end
        o_state.level    = level;
        o_state.offset   = pos;
        o_state.actuator = i_actuator;
        o_state.primed   = 1'b1;
    end

endmodule

/* sv/cfel_checker.sv */
// Port level checks of the calibration flag edge latch, bound to the top level.
module cfel_checker
    import cfel_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    logic       r_rise_sticky;
    logic       r_fall_sticky;
    logic [1:0] r_count;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_sticky <= 1'b0;
            r_fall_sticky <= 1'b0;
            r_count       <= 2'd0;
        end else begin
            if (out_acc && o_m_tdata[1]) begin
                r_rise_sticky <= 1'b1;
            end
            if (out_acc && o_m_tdata[34]) begin
                r_fall_sticky <= 1'b1;
            end
            r_count <= r_count + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    // Once a rising edge has been reported, every later item reports it too.
    a_rise_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_rise_sticky) |-> o_m_tdata[1])
        else $error("rise_seen dropped after being reported");

    a_fall_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_fall_sticky) |-> o_m_tdata[34])
        else $error("fall_seen dropped after being reported");

    // At most two items are held, and a result is only offered for an accepted item.
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3) && (!o_m_tvalid || (r_count != 2'd0)))
        else $error("items in flight out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind calibration_flag_edge_latch_unit cfel_checker u_cfel_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
